/* sv/spq_pkg.sv */
// Package for the stable priority queue: request and response structs,
// the stored entry type, the per-cell command, and status and opcode constants.
// Depends on nothing.
package spq_pkg;

  localparam int SPQ_DEPTH = 16;

  localparam logic       OP_ENQ = 1'b0;
  localparam logic       OP_DEQ = 1'b1;

  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_DEQ   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] proc_id;
    logic [6:0]  priority_req;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [6:0]  out_priority;
    logic [4:0]  occupancy;
  } spq_rsp_t;

  typedef struct packed {
    logic [15:0] id;
    logic [6:0]  prio;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t ent;
  } spq_cmd_t;

endpackage

/* sv/spq_cell.sv */
// One cell of the insertion queue: holds a single entry and moves it toward
// or away from the front on a broadcast command. Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_cmd_t  cmd,
  input  logic               occ,
  input  logic               prev_keep,
  input  spq_pkg::spq_entry_t prev_ent,
  input  spq_pkg::spq_entry_t next_ent,
  output logic               keep,
  output spq_pkg::spq_entry_t ent
);
  import spq_pkg::*;

  spq_entry_t ent_r;
  spq_entry_t ent_nxt;

  // A cell keeps its entry when it holds one that ranks at or above the new one.
  assign keep = occ && (ent_r.prio >= cmd.ent.prio);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.enq) begin
      if (!keep) begin
        ent_nxt = prev_keep ? cmd.ent : prev_ent;
      end
    end else if (cmd.deq) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

/* sv/stable_priority_queue_unit.sv */
// Top level of the stable priority queue: a row of spq_cell instances, the
// occupancy counter and the response register. Depends on spq_pkg and spq_cell.
//
// Usage: each request on the in_ channel is one command, enqueue or dequeue.
// An enqueue places its entry behind every stored entry of equal or higher
// priority, so equal priorities leave in arrival order. A dequeue returns the
// front entry. Every request yields exactly one response on the out_ channel
// carrying a status, the dequeued entry (zero otherwise) and the occupancy.
// An enqueue into a full queue and a dequeue from an empty one change nothing.
// out_valid rises in the cycle after acceptance. While in_stall is low, one
// request is accepted every cycle: all cells compare against the broadcast
// priority at once and shift by one place in the same cycle. When the receiver
// stalls, the response register holds its value and in_stall is raised until
// the response is taken. Reset empties the queue and drops any pending response;
// cell contents are not cleared, since only occupied cells are ever read.
module stable_priority_queue_unit #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_rsp_t out_rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  spq_rsp_t         out_rsp_r;
  spq_rsp_t         out_rsp_nxt;
  logic             accept;
  logic             full;
  logic             empty;
  spq_cmd_t         cmd;
  logic             keep  [QUEUE_DEPTH];
  spq_entry_t       ents  [QUEUE_DEPTH];

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign cmd.enq      = accept && (in_req.op == OP_ENQ) && !full;
  assign cmd.deq      = accept && (in_req.op == OP_DEQ) && !empty;
  assign cmd.ent.id   = in_req.proc_id;
  assign cmd.ent.prio = in_req.priority_req;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic       occ;
    logic       prev_keep;
    spq_entry_t prev_ent;
    spq_entry_t next_ent;

    assign occ = (IDX < cnt_r);

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_ent  = cmd.ent;
    end else begin : g_mid
      assign prev_keep = keep[i-1];
      assign prev_ent  = ents[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_ent = ents[i];
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ),
      .prev_keep (prev_keep),
      .prev_ent  (prev_ent),
      .next_ent  (next_ent),
      .keep      (keep[i]),
      .ent       (ents[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.enq) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.deq) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    out_rsp_nxt.out_id       = '0;
    out_rsp_nxt.out_priority = '0;
    if (in_req.op == OP_ENQ) begin
      out_rsp_nxt.status = full ? ST_FULL : ST_ENQ;
    end else if (empty) begin
      out_rsp_nxt.status = ST_EMPTY;
    end else begin
      out_rsp_nxt.status       = ST_DEQ;
      out_rsp_nxt.out_id       = ents[0].id;
      out_rsp_nxt.out_priority = ents[0].prio;
    end
    out_rsp_nxt.occupancy = 5'(cnt_nxt);

    out_valid_nxt = accept || in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

endmodule

/* sv/spq_chk.sv */
// Port-level checks for the stable priority queue, bound to its top level.
// Depends on spq_pkg and stable_priority_queue_unit.
module spq_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input spq_pkg::spq_rsp_t out_rsp
);
  import spq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("Stalled response changed or vanished.");

  a_req_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted request produced no response.");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("Input stalled with no pending response.");

  a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != ST_DEQ) |->
      (out_rsp.out_id == '0) && (out_rsp.out_priority == '0))
    else $error("Non-dequeue response carries an entry.");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_EMPTY) |-> (out_rsp.occupancy == '0))
    else $error("Empty error reported with nonzero occupancy.");

endmodule

bind stable_priority_queue_unit spq_chk u_chk (.*);
